// ===== src/tpc_pkg.sv =====
package tpc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned NormW  = 16;
  localparam int unsigned RadW   = 31;
  localparam int unsigned NormFrac = 14;
  localparam int unsigned DiffW  = 33;
  localparam int unsigned CfgIdxW = 3;

  // Square root of a 64-bit value: one result bit per cell.
  localparam int unsigned SqrtSteps = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_NORMAL_X = 3'd3,
    REG_NORMAL_Y = 3'd4,
    REG_NORMAL_Z = 3'd5,
    REG_RING_RAD = 3'd6,
    REG_TUBE_RAD = 3'd7
  } cfg_reg_e;

  // Square-root working state handed from cell to cell.
  typedef struct packed {
    logic        valid;
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_q;
    logic        out_fast;   // result already decided
    logic        inside_fast;
    logic        on_axis;
    logic [63:0] rhs;        // r^2 - h^2
    logic [30:0] ring;
  } sqrt_stage_t;

endpackage

// ===== src/tpc_sqrt_cell.sv =====
module tpc_sqrt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tpc_pkg::sqrt_stage_t stage_i,
  output tpc_pkg::sqrt_stage_t stage_o
);

  tpc_pkg::sqrt_stage_t stage_d, stage_q;
  logic [63:0] trial;

  always_comb begin
    stage_d = stage_i;
    trial = stage_i.res + stage_i.bit_q;
    if (stage_i.rem >= trial) begin
      stage_d.rem = stage_i.rem - trial;
      stage_d.res = (stage_i.res >> 1) + stage_i.bit_q;
    end else begin
      stage_d.res = stage_i.res >> 1;
    end
    stage_d.bit_q = stage_i.bit_q >> 2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

// ===== src/tpc_front.sv =====
module tpc_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [31:0]          px_i,
  input  logic signed [31:0]          py_i,
  input  logic signed [31:0]          pz_i,
  input  logic signed [31:0]          cx_i,
  input  logic signed [31:0]          cy_i,
  input  logic signed [31:0]          cz_i,
  input  logic signed [15:0]          nx_i,
  input  logic signed [15:0]          ny_i,
  input  logic signed [15:0]          nz_i,
  input  logic [30:0]                 ring_i,
  input  logic [30:0]                 tube_i,
  output tpc_pkg::sqrt_stage_t        stage_o
);

  // Stage 1: offsets and products with the normal.
  logic               v1_q, v2_q, v3_q;
  logic signed [32:0] d_d [3];
  logic signed [32:0] d1_q [3], d2_q [3];
  logic signed [15:0] n_d [3];
  logic signed [48:0] pr1_q [3];
  logic signed [50:0] dot_d;
  logic signed [36:0] h_d, h3_q;
  logic signed [52:0] hn_q [3];
  logic signed [64:0] p_d [3];
  logic        big_d;
  logic [31:0] m_d [3];
  logic [63:0] sq_q [3];
  logic        big_q;
  logic [36:0] hm_d;
  logic [61:0] r2_q;
  logic [61:0] h2_q;
  logic        hfar_q;
  logic [30:0] ring2_q, ring3_q, ring4_q;
  logic [65:0] s_d;
  logic        ovf4_d;
  tpc_pkg::sqrt_stage_t st_d;
  logic [63:0] bit_d;

  assign d_d[0] = 33'(px_i) - 33'(cx_i);
  assign d_d[1] = 33'(py_i) - 33'(cy_i);
  assign d_d[2] = 33'(pz_i) - 33'(cz_i);
  assign n_d[0] = nx_i;
  assign n_d[1] = ny_i;
  assign n_d[2] = nz_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 2: height along the axis.
  assign dot_d = 51'(pr1_q[0]) + 51'(pr1_q[1]) + 51'(pr1_q[2]);
  assign h_d   = 37'(dot_d >>> tpc_pkg::NormFrac);

  // Stage 3: projection onto the ring plane and its magnitude checks.
  always_comb begin
    big_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      p_d[i] = 65'(d2_q[i]) - 65'(hn_q[i] >>> tpc_pkg::NormFrac);
      m_d[i] = p_d[i][64] ? 32'(-p_d[i]) : p_d[i][31:0];
      if ((p_d[i][64] ? 65'(-p_d[i]) : p_d[i]) >= 65'h1_0000_0000) big_d = 1'b1;
    end
  end
  assign hm_d = h3_q[36] ? 37'(-h3_q) : h3_q;

  // The height square only matters when the height is below the tube radius,
  // so its low 31 bits are enough.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i]  <= d_d[i];
        pr1_q[i] <= 49'(d_d[i]) * 49'(n_d[i]);
        d2_q[i]  <= d1_q[i];
        hn_q[i]  <= 53'(h_d) * 53'(n_d[i]);
        sq_q[i]  <= 64'(m_d[i]) * 64'(m_d[i]);
      end
      h3_q    <= h_d;
      ring2_q <= ring_i;
      ring3_q <= ring2_q;
      ring4_q <= ring3_q;
      big_q   <= big_d;
      hfar_q  <= hm_d >= 37'(tube_i);
      r2_q    <= 62'(tube_i) * 62'(tube_i);
      h2_q    <= 62'(hm_d[30:0]) * 62'(hm_d[30:0]);
    end
  end

  // Stage 4: sum of squares, early decisions, square-root seed.
  assign s_d    = 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);
  assign ovf4_d = s_d[65] | s_d[64];

  always_comb begin
    bit_d = 64'h4000_0000_0000_0000;
    st_d = '0;
    st_d.valid = v3_q;
    st_d.rem   = s_d[63:0];
    st_d.res   = '0;
    st_d.bit_q = bit_d;
    st_d.ring  = ring4_q;
    st_d.rhs   = 64'(r2_q) - 64'(h2_q);
    st_d.out_fast = 1'b1;
    st_d.inside_fast = 1'b0;
    st_d.on_axis = 1'b0;
    if (big_q || ovf4_d) begin
      st_d.out_fast = 1'b1;
    end else if (s_d == '0) begin
      st_d.on_axis = 1'b1;
    end else if (!hfar_q) begin
      st_d.out_fast = 1'b0;
    end
  end

  tpc_sqrt_cell u_seed (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .stage_i (st_d),
    .stage_o (stage_o)
  );

endmodule

// ===== src/tpc_back.sv =====
module tpc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  tpc_pkg::sqrt_stage_t stage_i,
  output logic                 valid_o,
  output logic                 inside_o,
  output logic                 on_axis_o
);

  logic        v_q, in_q, ax_q, fast_q;
  logic [63:0] rhs_q, diff2_d;
  logic [32:0] diff_d;
  logic [32:0] dmag_d;
  logic [63:0] diff2_q;

  assign diff_d = 33'(stage_i.res[31:0]) - 33'(stage_i.ring);
  assign dmag_d = diff_d[32] ? -diff_d : diff_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q <= stage_i.valid;
      valid_o <= v_q;
    end
  end

  assign diff2_d = diff2_q;

  // The magnitude is below 2^32, so its square fits in 64 bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff2_q   <= 64'(dmag_d) * 64'(dmag_d);
      rhs_q     <= stage_i.rhs;
      fast_q    <= stage_i.out_fast;
      in_q      <= stage_i.inside_fast;
      ax_q      <= stage_i.on_axis;
      inside_o  <= fast_q ? in_q : (diff2_d < rhs_q);
      on_axis_o <= ax_q;
    end
  end

endmodule

// ===== src/torus_point_containment_top.sv =====
// Throughput: one transaction per cycle; the chain stalls as a whole only while a
// finished result waits at the output and the skid register is full.
// Reset: asynchronous and active low; clears all valid flags and loads the
// register reset values (center 0, normal +z, ring radius 2.0, tube radius 1.0).
module torus_point_containment_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               inside_res_o,
  output logic               on_axis_o
);

  logic signed [31:0] cx_q, cy_q, cz_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic [30:0]        ring_q, tube_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      nx_q <= '0;
      ny_q <= '0;
      nz_q <= 16'sd16384;
      ring_q <= 31'd131072;
      tube_q <= 31'd65536;
    end else if (cfg_we_i) begin
      unique case (tpc_pkg::cfg_reg_e'(cfg_idx_i))
        tpc_pkg::REG_CENTER_X: cx_q <= cfg_data_i;
        tpc_pkg::REG_CENTER_Y: cy_q <= cfg_data_i;
        tpc_pkg::REG_CENTER_Z: cz_q <= cfg_data_i;
        tpc_pkg::REG_NORMAL_X: nx_q <= cfg_data_i[15:0];
        tpc_pkg::REG_NORMAL_Y: ny_q <= cfg_data_i[15:0];
        tpc_pkg::REG_NORMAL_Z: nz_q <= cfg_data_i[15:0];
        tpc_pkg::REG_RING_RAD: ring_q <= cfg_data_i[30:0];
        tpc_pkg::REG_TUBE_RAD: tube_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // The whole chain advances together whenever the output skid stage has room.
  // A result leaving the chain lands in the main output register or, if that
  // one is held, in the skid register; ready is taken from the skid being empty.
  logic en;
  logic pipe_valid, pipe_inside, pipe_axis;
  logic skid_v_q, skid_in_q, skid_ax_q;
  logic out_v_q, out_in_q, out_ax_q;

  assign en = !skid_v_q;
  assign in_ready_o = en;

  tpc_pkg::sqrt_stage_t chain [tpc_pkg::SqrtSteps];

  tpc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .px_i    (point_x_i),
    .py_i    (point_y_i),
    .pz_i    (point_z_i),
    .cx_i    (cx_q),
    .cy_i    (cy_q),
    .cz_i    (cz_q),
    .nx_i    (nx_q),
    .ny_i    (ny_q),
    .nz_i    (nz_q),
    .ring_i  (ring_q),
    .tube_i  (tube_q),
    .stage_o (chain[0])
  );

  // One square-root result bit per cell; the seed cell lives in the front end,
  // so the row here holds the remaining steps.
  for (genvar g = 0; g < tpc_pkg::SqrtSteps - 1; g++) begin : g_cell
    tpc_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (chain[g]),
      .stage_o (chain[g+1])
    );
  end

  tpc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .stage_i   (chain[tpc_pkg::SqrtSteps-1]),
    .valid_o   (pipe_valid),
    .inside_o  (pipe_inside),
    .on_axis_o (pipe_axis)
  );

  logic out_take, pipe_push;
  assign out_take  = out_v_q && out_ready_i;
  assign pipe_push = en && pipe_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || out_take) begin
        if (skid_v_q) begin
          out_v_q  <= 1'b1;
          out_in_q <= skid_in_q;
          out_ax_q <= skid_ax_q;
          skid_v_q <= 1'b0;
        end else begin
          out_v_q  <= pipe_push;
          out_in_q <= pipe_inside;
          out_ax_q <= pipe_axis;
        end
      end else if (pipe_push) begin
        skid_v_q  <= 1'b1;
        skid_in_q <= pipe_inside;
        skid_ax_q <= pipe_axis;
      end
    end
  end

  assign out_valid_o  = out_v_q;
  assign inside_res_o = out_in_q;
  assign on_axis_o    = out_ax_q;

endmodule

// ===== src/tpc_checker.sv =====
module tpc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic inside_res_o,
  input logic on_axis_o
);

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(inside_res_o && on_axis_o))
    else $error("inside and on-axis both set");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(inside_res_o))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending output");

endmodule

bind torus_point_containment_top tpc_checker u_tpc_checker (.*);
